/* rtl/suag_pkg.sv */
// Shared types and constants of the slice update address generator.
// No dependencies; every other file of the block imports this package.
package suag_pkg;

  localparam int NFIELDS          = 4;
  localparam int FIELD_IDX_W      = 2;
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_OPERAND_BASE = 0;
  localparam int CFG_UPDATE_BASE  = 4;
  localparam int OUT_ADDR_W       = 32;
  localparam int DATA_W           = 64;
  localparam int START_W          = 64;

  localparam logic OP_START   = 1'b0;
  localparam logic OP_ELEMENT = 1'b1;

  typedef struct packed {
    logic                      op;
    logic signed [START_W-1:0] start_index_0;
    logic signed [START_W-1:0] start_index_1;
    logic signed [START_W-1:0] start_index_2;
    logic signed [START_W-1:0] start_index_3;
    logic [DATA_W-1:0]         element_value;
  } in_req_t;

  typedef struct packed {
    logic [OUT_ADDR_W-1:0] write_address;
    logic [DATA_W-1:0]     write_data;
    logic                  last_write;
  } out_req_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start_load;
    logic elem_accept;
    logic mul_load;
    logic mul_base;
    logic acc_clear;
    logic mul_step;
    logic stride_wr;
    logic finish;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_valid;
    logic block_active;
  } dp_stat_t;

endpackage

/* rtl/slice_update_address_generator_unit.sv */
// Slice update address generator. An op=0 request clamps four signed start
// indices against the operand and update sizes and then computes the row
// strides and base address on a shared shift-add multiplier, one multiplier
// bit per cycle: the input stays closed from the moment the start request is
// taken until the base address is latched, and no result is produced. An op=1
// request carries one update element in row-major order; it yields one write
// request with the flat address, the element bits and a last flag on the final
// element, so elements stream at one per cycle while the output side keeps up.
// The output register lets a new element be taken in the same cycle the
// previous write is consumed. Elements that arrive with no active block, or
// after an empty update, produce no write.
// Configuration registers 0..3 hold the operand sizes and 4..7 the update
// sizes (outermost first); they take effect at the next start request.
// Depends on suag_pkg, suag_ctrl and suag_datapath.
module slice_update_address_generator_unit #(
  parameter int RANK       = 4,
  parameter int ADDR_WIDTH = 32,
  parameter int DIM_WIDTH  = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [suag_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_WIDTH-1:0]           cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  suag_pkg::in_req_t              in_req,
  output logic                           out_valid,
  input  logic                           out_ready,
  output suag_pkg::out_req_t             out_req
);
  import suag_pkg::*;

  // Width of a dimension index.
  localparam int IDX_W = (RANK > 1) ? $clog2(RANK) : 1;

  dp_cmd_t          cmd;
  dp_stat_t         stat;
  logic [IDX_W-1:0] sel_idx;
  logic [IDX_W-1:0] wr_idx;

  // The controller sequences the start computation and the handshake.
  suag_ctrl #(
    .RANK      (RANK),
    .DIM_WIDTH (DIM_WIDTH),
    .IDX_W     (IDX_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_req.op),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd),
    .sel_idx   (sel_idx),
    .wr_idx    (wr_idx)
  );

  // The datapath holds all geometry, the address odometer and the output.
  suag_datapath #(
    .RANK       (RANK),
    .ADDR_WIDTH (ADDR_WIDTH),
    .DIM_WIDTH  (DIM_WIDTH),
    .IDX_W      (IDX_W)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_req    (in_req),
    .cmd       (cmd),
    .sel_idx   (sel_idx),
    .wr_idx    (wr_idx),
    .out_ready (out_ready),
    .out_req   (out_req),
    .stat      (stat)
  );

  assign out_valid = stat.out_valid;

endmodule

/* rtl/suag_datapath.sv */
// Datapath of the slice update address generator: configuration registers,
// start clamping, shift-add multiply unit, odometer counters and output register.
// Depends on suag_pkg.
module suag_datapath #(
  parameter int RANK       = 4,
  parameter int ADDR_WIDTH = 32,
  parameter int DIM_WIDTH  = 16,
  parameter int IDX_W      = 2
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [suag_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_WIDTH-1:0]           cfg_data,
  input  suag_pkg::in_req_t              in_req,
  input  suag_pkg::dp_cmd_t              cmd,
  input  logic [IDX_W-1:0]               sel_idx,
  input  logic [IDX_W-1:0]               wr_idx,
  input  logic                           out_ready,
  output suag_pkg::out_req_t             out_req,
  output suag_pkg::dp_stat_t             stat
);
  import suag_pkg::*;

  logic [DIM_WIDTH-1:0]  cfg_osz_r [NFIELDS];
  logic [DIM_WIDTH-1:0]  cfg_usz_r [NFIELDS];

  logic [DIM_WIDTH-1:0]  osz_in    [RANK];
  logic [DIM_WIDTH-1:0]  usz_in    [RANK];
  logic [DIM_WIDTH-1:0]  clamp_in  [RANK];
  logic signed [START_W-1:0] start_arr [NFIELDS];

  logic [DIM_WIDTH-1:0]  osz_r     [RANK];
  logic [DIM_WIDTH-1:0]  ext_r     [RANK];
  logic [DIM_WIDTH-1:0]  cstart_r  [RANK];
  logic [DIM_WIDTH-1:0]  pos_r     [RANK];
  logic [ADDR_WIDTH-1:0] stride_r  [RANK];
  logic [ADDR_WIDTH-1:0] line_r    [RANK];

  logic [ADDR_WIDTH-1:0] mul_a_r;
  logic [DIM_WIDTH-1:0]  mul_b_r;
  logic [ADDR_WIDTH-1:0] acc_r;

  logic                  block_active_r;
  logic                  out_valid_r;
  out_req_t              out_req_r;

  logic                  found;
  logic [IDX_W-1:0]      sel_adv;
  logic [ADDR_WIDTH-1:0] new_line;
  logic                  empty;
  logic                  elem_step;

  assign start_arr[0] = in_req.start_index_0;
  assign start_arr[1] = in_req.start_index_1;
  assign start_arr[2] = in_req.start_index_2;
  assign start_arr[3] = in_req.start_index_3;

  // Configuration registers; the low index bits pick the dimension.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NFIELDS; i++) begin
        cfg_osz_r[i] <= DIM_WIDTH'(1);
        cfg_usz_r[i] <= DIM_WIDTH'(1);
      end
    end else if (cfg_we) begin
      if (cfg_index < CFG_IDX_W'(CFG_UPDATE_BASE)) begin
        cfg_osz_r[cfg_index[FIELD_IDX_W-1:0]] <= cfg_data;
      end else begin
        cfg_usz_r[cfg_index[FIELD_IDX_W-1:0]] <= cfg_data;
      end
    end
  end

  // Per-dimension sizes and clamped start. Dimensions past the configured
  // ones have size one and start zero.
  for (genvar d = 0; d < RANK; d++) begin : g_dim
    logic [DIM_WIDTH-1:0] hi;
    if (d < NFIELDS) begin : g_cfg
      assign osz_in[d] = cfg_osz_r[d];
      assign usz_in[d] = cfg_usz_r[d];
      assign hi = (cfg_osz_r[d] >= cfg_usz_r[d]) ? (cfg_osz_r[d] - cfg_usz_r[d]) : '0;
      always_comb begin
        if (start_arr[d][START_W-1]) begin
          clamp_in[d] = '0;
        end else if ((|start_arr[d][START_W-2:DIM_WIDTH]) ||
                     (start_arr[d][DIM_WIDTH-1:0] > hi)) begin
          clamp_in[d] = hi;
        end else begin
          clamp_in[d] = start_arr[d][DIM_WIDTH-1:0];
        end
      end
    end else begin : g_pad
      assign osz_in[d]   = DIM_WIDTH'(1);
      assign usz_in[d]   = DIM_WIDTH'(1);
      assign hi          = '0;
      assign clamp_in[d] = hi;
    end
  end

  // Innermost dimension whose counter can still advance.
  always_comb begin
    found   = 1'b0;
    sel_adv = '0;
    empty   = 1'b0;
    for (int d = 0; d < RANK; d++) begin
      if (({1'b0, pos_r[d]} + 1'b1) < {1'b0, ext_r[d]}) begin
        found   = 1'b1;
        sel_adv = IDX_W'(d);
      end
      if (ext_r[d] == '0) begin
        empty = 1'b1;
      end
    end
  end

  assign new_line  = line_r[sel_adv] + stride_r[sel_adv];
  assign elem_step = cmd.elem_accept && block_active_r;

  // Shift-add multiply-accumulate: one multiplier bit per cycle.
  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      mul_a_r <= stride_r[sel_idx];
      mul_b_r <= cmd.mul_base ? cstart_r[sel_idx] : osz_r[sel_idx];
      if (cmd.acc_clear) begin
        acc_r <= '0;
      end
    end else if (cmd.mul_step) begin
      if (mul_b_r[0]) begin
        acc_r <= acc_r + mul_a_r;
      end
      mul_a_r <= mul_a_r << 1;
      mul_b_r <= mul_b_r >> 1;
    end
  end

  // Latched block geometry, strides and odometer.
  always_ff @(posedge clk) begin
    if (cmd.start_load) begin
      for (int d = 0; d < RANK; d++) begin
        osz_r[d]    <= osz_in[d];
        ext_r[d]    <= usz_in[d];
        cstart_r[d] <= clamp_in[d];
        pos_r[d]    <= '0;
      end
      stride_r[RANK-1] <= ADDR_WIDTH'(1);
    end
    if (cmd.stride_wr) begin
      stride_r[wr_idx] <= acc_r;
    end
    if (cmd.finish) begin
      for (int d = 0; d < RANK; d++) begin
        line_r[d] <= acc_r;
      end
    end
    if (elem_step) begin
      for (int d = 0; d < RANK; d++) begin
        if (!found) begin
          pos_r[d] <= '0;
        end else if (IDX_W'(d) == sel_adv) begin
          pos_r[d]  <= pos_r[d] + DIM_WIDTH'(1);
          line_r[d] <= new_line;
        end else if (IDX_W'(d) > sel_adv) begin
          pos_r[d]  <= '0;
          line_r[d] <= new_line;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_active_r <= 1'b0;
    end else if (cmd.start_load) begin
      block_active_r <= 1'b0;
    end else if (cmd.finish) begin
      block_active_r <= !empty;
    end else if (elem_step && !found) begin
      block_active_r <= 1'b0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (elem_step) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (elem_step) begin
      out_req_r.write_address <= OUT_ADDR_W'(line_r[RANK-1]);
      out_req_r.write_data    <= in_req.element_value;
      out_req_r.last_write    <= !found;
    end
  end

  assign out_req           = out_req_r;
  assign stat.out_valid    = out_valid_r;
  assign stat.block_active = block_active_r;

  // An active block never has an empty extent.
  a_active_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    block_active_r |-> !empty)
    else $error("active block with an empty extent");

  // The multiplier only runs while no block streams.
  a_mul_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul_step |-> !block_active_r)
    else $error("multiplier stepped during an active block");

  // Every counter stays inside its extent while a block is active.
  for (genvar d = 0; d < RANK; d++) begin : g_chk
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
      block_active_r |-> (pos_r[d] < ext_r[d]))
      else $error("position counter beyond its extent");
  end

endmodule

/* rtl/suag_ctrl.sv */
// Controller of the slice update address generator: handshake and the
// sequence of stride and base multiplications after a start request.
// Depends on suag_pkg.
module suag_ctrl #(
  parameter int RANK      = 4,
  parameter int DIM_WIDTH = 16,
  parameter int IDX_W     = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_op,
  output logic               in_ready,
  input  logic               out_ready,
  input  suag_pkg::dp_stat_t stat,
  output suag_pkg::dp_cmd_t  cmd,
  output logic [IDX_W-1:0]   sel_idx,
  output logic [IDX_W-1:0]   wr_idx
);
  import suag_pkg::*;

  localparam int CNT_W = $clog2(DIM_WIDTH);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SLOAD  = 7'b0000010,
    S_SMUL   = 7'b0000100,
    S_SSTORE = 7'b0001000,
    S_BLOAD  = 7'b0010000,
    S_BMUL   = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] dim_r, dim_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             accept;
  logic             cnt_last;

  assign in_ready = (state_r == S_IDLE) && (!stat.out_valid || out_ready);
  assign accept   = in_valid && in_ready;
  assign cnt_last = (cnt_r == CNT_W'(DIM_WIDTH - 1));
  assign wr_idx   = dim_r;
  assign sel_idx  = (state_r == S_SLOAD) ? IDX_W'(dim_r + 1'b1) : dim_r;

  always_comb begin
    state_nxt = state_r;
    dim_nxt   = dim_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_op == OP_START) begin
            cmd.start_load = 1'b1;
            if (RANK > 1) begin
              state_nxt = S_SLOAD;
              dim_nxt   = IDX_W'(RANK - 2);
            end else begin
              state_nxt = S_BLOAD;
              dim_nxt   = '0;
            end
          end else begin
            cmd.elem_accept = 1'b1;
          end
        end
      end
      S_SLOAD: begin
        cmd.mul_load  = 1'b1;
        cmd.acc_clear = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = S_SMUL;
      end
      S_SMUL: begin
        cmd.mul_step = 1'b1;
        if (cnt_last) begin
          cnt_nxt   = '0;
          state_nxt = S_SSTORE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_SSTORE: begin
        cmd.stride_wr = 1'b1;
        if (dim_r == '0) begin
          state_nxt = S_BLOAD;
        end else begin
          dim_nxt   = dim_r - 1'b1;
          state_nxt = S_SLOAD;
        end
      end
      S_BLOAD: begin
        cmd.mul_load  = 1'b1;
        cmd.mul_base  = 1'b1;
        cmd.acc_clear = (dim_r == '0);
        cnt_nxt       = '0;
        state_nxt     = S_BMUL;
      end
      S_BMUL: begin
        cmd.mul_step = 1'b1;
        if (cnt_last) begin
          cnt_nxt = '0;
          if (dim_r == IDX_W'(RANK - 1)) begin
            state_nxt = S_DONE;
          end else begin
            dim_nxt   = dim_r + 1'b1;
            state_nxt = S_BLOAD;
          end
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      dim_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      dim_r   <= dim_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // The bit counter only moves inside the multiply states.
  a_cnt_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0) |-> (state_r == S_SMUL || state_r == S_BMUL))
    else $error("bit counter running outside a multiply");

  // A start request closes the input until the geometry is computed.
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_op == OP_START) |=> !in_ready)
    else $error("input open right after a start request");

endmodule

/* tb/suag_checker.sv */
`timescale 1ns / 100ps
// Checker for the slice update address generator: predicts every write request
// from the accepted requests and configuration writes, and compares the results.
// Depends on suag_pkg for the request types and configuration indexes.
module suag_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [suag_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                    cfg_data,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  suag_pkg::in_req_t              in_req,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  suag_pkg::out_req_t             out_req,
  output int                             mismatches,
  output int                             awaited
);
  import suag_pkg::*;

  logic [15:0] operand_size [NFIELDS];
  logic [15:0] update_size  [NFIELDS];

  // State latched by the last start request.
  logic [15:0] slice_start [NFIELDS];
  logic [15:0] extent      [NFIELDS];
  logic [31:0] stride      [NFIELDS];
  logic [15:0] position    [NFIELDS];
  logic [31:0] line_base   [NFIELDS];
  logic [31:0] next_address;
  logic        writing;

  out_req_t write_q [$];
  int       errors = 0;

  function automatic logic [15:0] clamp_start(logic signed [63:0] raw, logic [15:0] osz,
                                              logic [15:0] usz);
    logic [15:0] upper;
    upper = (osz >= usz) ? osz - usz : 16'd0;
    if (raw[63]) return 16'd0;
    if (raw > $signed({48'd0, upper})) return upper;
    return raw[15:0];
  endfunction

  function automatic void clear_state();
    int d;
    for (d = 0; d < NFIELDS; d++) begin
      operand_size[d] = 16'd1;
      update_size[d]  = 16'd1;
      slice_start[d]  = '0;
      extent[d]       = '0;
      stride[d]       = 32'd1;
      position[d]     = '0;
      line_base[d]    = '0;
    end
    next_address = '0;
    writing      = 1'b0;
  endfunction

  function automatic void latch_slice(in_req_t r);
    logic signed [63:0] raw [NFIELDS];
    logic [31:0] base;
    logic        empty;
    int d;
    raw[0] = r.start_index_0;
    raw[1] = r.start_index_1;
    raw[2] = r.start_index_2;
    raw[3] = r.start_index_3;
    empty  = 1'b0;
    for (d = 0; d < NFIELDS; d++) begin
      extent[d] = update_size[d];
      if (update_size[d] == 16'd0) empty = 1'b1;
    end
    stride[NFIELDS-1] = 32'd1;
    for (d = NFIELDS - 2; d >= 0; d--)
      stride[d] = stride[d+1] * {16'd0, operand_size[d+1]};
    base = '0;
    for (d = 0; d < NFIELDS; d++) begin
      slice_start[d] = clamp_start(raw[d], operand_size[d], extent[d]);
      base           = base + {16'd0, slice_start[d]} * stride[d];
      position[d]    = '0;
    end
    for (d = 0; d < NFIELDS; d++) line_base[d] = base;
    next_address = base;
    writing      = !empty;
  endfunction

  // Steps the row-major position like an odometer, innermost dimension first.
  function automatic void place_element(in_req_t r);
    out_req_t w;
    logic     stepped;
    int d, k;
    if (!writing) return;
    w.write_address = next_address;
    w.write_data    = r.element_value;
    stepped         = 1'b0;
    for (d = NFIELDS - 1; d >= 0; d--) begin
      if (!stepped) begin
        if (int'(position[d]) + 1 < int'(extent[d])) begin
          position[d]  = position[d] + 16'd1;
          line_base[d] = line_base[d] + stride[d];
          for (k = d + 1; k < NFIELDS; k++) line_base[k] = line_base[d];
          stepped = 1'b1;
        end else begin
          position[d] = '0;
        end
      end
    end
    next_address = line_base[NFIELDS-1];
    w.last_write = !stepped;
    if (!stepped) writing = 1'b0;
    write_q = {write_q, w};
  endfunction

  always @(posedge clk) begin
    out_req_t want;
    if (!rst_n) begin
      clear_state();
      write_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (write_q.size() == 0) begin
          $error("write request with none expected: address %h data %h last %b",
                 out_req.write_address, out_req.write_data, out_req.last_write);
          errors++;
        end else begin
          want = write_q.pop_front();
          if (out_req.write_address !== want.write_address) begin
            $error("write_address: expected %h, got %h", want.write_address,
                   out_req.write_address);
            errors++;
          end
          if (out_req.write_data !== want.write_data) begin
            $error("write_data: expected %h, got %h", want.write_data, out_req.write_data);
            errors++;
          end
          if (out_req.last_write !== want.last_write) begin
            $error("last_write: expected %b, got %b", want.last_write, out_req.last_write);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (in_req.op == OP_START) latch_slice(in_req);
        else place_element(in_req);
      end
      if (cfg_we) begin
        if (cfg_index < CFG_UPDATE_BASE) operand_size[cfg_index - CFG_OPERAND_BASE] = cfg_data;
        else update_size[cfg_index - CFG_UPDATE_BASE] = cfg_data;
      end
    end
    mismatches <= errors;
    awaited    <= write_q.size();
  end

endmodule

/* tb/slice_update_address_generator_unit_tb.sv */
`timescale 1ns / 100ps
// Top of the slice update address generator testbench: clock, reset, stimulus
// and verdict. Depends on suag_pkg, suag_checker and the block under test.
module slice_update_address_generator_unit_tb;
  import suag_pkg::*;

  localparam int DIM_W        = 16;
  // A start request closes the input while it sets up; this covers it with margin.
  localparam int START_SETTLE = 130;
  localparam int BACKLOG_HOLD = 200;
  localparam int RANDOM_ITEMS = 450;
  localparam int RUN_LIMIT_NS = 5_000_000;

  typedef logic [NFIELDS-1:0][DIM_W-1:0] size_set_t;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]     cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_req_t              in_req    = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_req_t             out_req;
  int                   mismatches;
  int                   awaited;

  // Idling modes, changed per phase by the stimulus process.
  bit          feed_idles    = 1'b1;
  bit          sink_idles    = 1'b1;
  // The sink holds off once for a long stretch after this is set.
  bit          backlog_armed = 1'b0;
  bit          backlog_done  = 1'b0;
  int unsigned items_sent    = 0;

  slice_update_address_generator_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_req   (out_req)
  );

  suag_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_req     (in_req),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_req    (out_req),
    .mismatches (mismatches),
    .awaited    (awaited)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case a handshake never completes or a write never arrives.
  initial begin
    #RUN_LIMIT_NS;
    $display("slice_update_address_generator_unit_tb failed");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic size_set_t sizes(int a, int b, int c, int d);
    size_set_t s;
    s[0] = DIM_W'(a);
    s[1] = DIM_W'(b);
    s[2] = DIM_W'(c);
    s[3] = DIM_W'(d);
    return s;
  endfunction

  // Start requests carry random bits in the element field, and element
  // requests random bits in the index fields, since the block ignores them.
  function automatic in_req_t make_start(logic [63:0] i0, logic [63:0] i1, logic [63:0] i2,
                                         logic [63:0] i3);
    in_req_t r;
    r.op            = OP_START;
    r.start_index_0 = i0;
    r.start_index_1 = i1;
    r.start_index_2 = i2;
    r.start_index_3 = i3;
    r.element_value = rand64();
    return r;
  endfunction

  function automatic in_req_t make_element(logic [63:0] value);
    in_req_t r;
    r.op            = OP_ELEMENT;
    r.start_index_0 = rand64();
    r.start_index_1 = rand64();
    r.start_index_2 = rand64();
    r.start_index_3 = rand64();
    r.element_value = value;
    return r;
  endfunction

  function automatic logic [63:0] random_element();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return rand64();
  endfunction

  // Start index mix: values near the valid range so the clamp edges are hit,
  // plus negative, huge and fully random values.
  function automatic logic [63:0] pick_index(logic [DIM_W-1:0] osz);
    int unsigned roll;
    logic [63:0] v;
    roll = $urandom_range(0, 99);
    if (roll < 40) v = 64'($urandom_range(0, int'(osz) + 1));
    else if (roll < 55) v = rand64() | 64'h8000_0000_0000_0000;
    else if (roll < 70) v = rand64() >> 1;
    else if (roll < 85) v = rand64();
    else if (roll < 93) v = '1;
    else if (roll < 97) v = 64'h7FFF_FFFF_FFFF_FFFF;
    else v = 64'h8000_0000_0000_0000;
    return v;
  endfunction

  // Mostly no gap, sometimes a short one, rarely a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (!feed_idles) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offers one request and returns at the edge where it is taken. Valid stays
  // high across back-to-back requests and is only lowered before a gap.
  task automatic push_request(input in_req_t r);
    int unsigned pause;
    pause = pick_gap();
    if (pause > 0) begin
      in_valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stops offering and waits until every predicted write has come out. At
  // least one edge passes, so valid is never lowered and raised in one step.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited != 0);
  endtask

  // Register writes happen only with the block quiet: all writes out, and long
  // enough after that for any start request still setting up to finish.
  task automatic configure(input size_set_t osz, input size_set_t usz);
    int d;
    drain();
    repeat (START_SETTLE) @(posedge clk);
    for (d = 0; d < NFIELDS; d++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(CFG_OPERAND_BASE + d);
      cfg_data  <= osz[d];
      @(posedge clk);
    end
    for (d = 0; d < NFIELDS; d++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(CFG_UPDATE_BASE + d);
      cfg_data  <= usz[d];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic push_elements(input int count);
    repeat (count) push_request(make_element(random_element()));
  endtask

  // Result sink. Each cycle it either accepts or stalls; stalls are mostly
  // short with a few long ones. Once armed, it holds off for a long stretch
  // as soon as a write shows up, so the block backs up into its input.
  initial begin
    int unsigned stall_left;
    int unsigned roll;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (backlog_armed && !backlog_done && out_valid) begin
        out_ready   <= 1'b0;
        backlog_done = 1'b1;
        repeat (BACKLOG_HOLD) @(posedge clk);
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        roll = $urandom_range(0, 99);
        if (sink_idles) begin
          if (roll < 20) stall_left = $urandom_range(1, 3);
          else if (roll < 23) stall_left = $urandom_range(10, 40);
        end
      end
    end
  end

  initial begin
    size_set_t   osz, usz;
    int unsigned kind, blocks, roll, pick;
    int          count, d;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset sizes are all one. An element with no block is dropped, the most
    // negative start clamps to zero, and an element after the last is dropped.
    push_request(make_element(rand64()));
    push_request(make_start(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000,
                            64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000));
    push_request(make_element('1));
    push_request(make_element('0));

    // A 1x2x1x2 update into a 3x4x5x6 operand. The first start clamps high and
    // low; the second is paused while the sizes change under it, and its remaining
    // elements must still follow the strides latched at its start.
    configure(sizes(3, 4, 5, 6), sizes(1, 2, 1, 2));
    push_request(make_start(64'h7FFF_FFFF_FFFF_FFFF, '1, 64'd3, 64'd2));
    push_elements(4);
    push_request(make_start('0, '0, '0, '0));
    push_elements(2);
    configure(sizes(1, 1, 1, 1), sizes(0, 0, 0, 0));
    push_elements(2);

    // Largest operand, so strides and the base address wrap. The update spans
    // the whole outer dimension; only a few elements go in before it is dropped.
    configure(sizes(65535, 65535, 65535, 65535), sizes(65535, 1, 1, 2));
    push_request(make_start(64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF,
                            64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF));
    push_elements(3);

    // An empty update gives no writes at all.
    configure(sizes(2, 2, 2, 2), sizes(1, 0, 1, 1));
    push_request(make_start(64'd1, 64'd1, 64'd1, 64'd1));
    push_elements(1);

    // Update wider than the operand: the clamp saturates at zero.
    configure(sizes(2, 2, 2, 2), sizes(1, 1, 1, 3));
    push_request(make_start(64'd1, 64'd1, -64'sd5, 64'd7));
    push_elements(3);

    // Back-pressure: a steady element stream while the sink stalls for a long
    // stretch, which fills the output register and closes the input.
    feed_idles = 1'b0;
    sink_idles = 1'b0;
    configure(sizes(4, 4, 4, 4), sizes(1, 2, 2, 4));
    backlog_armed = 1'b1;
    push_request(make_start(64'd2, 64'd1, 64'd1, 64'd0));
    push_elements(16);
    drain();

    // Random phases: a fresh set of sizes, then several blocks. Most blocks are
    // sent whole; some are cut short by the next start, and some are followed
    // by stray elements that must be dropped.
    while (items_sent < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 9);
      for (d = 0; d < NFIELDS; d++) begin
        if (kind == 9) begin
          osz[d] = $urandom_range(0, 1) ? 16'hFFFF : DIM_W'($urandom_range(1, 65535));
          usz[d] = DIM_W'($urandom_range(1, 2));
        end else if (kind == 8) begin
          osz[d] = DIM_W'($urandom_range(1, 3));
          usz[d] = DIM_W'($urandom_range(1, 3));
        end else begin
          osz[d] = DIM_W'($urandom_range(1, 6));
          usz[d] = DIM_W'($urandom_range(1, (osz[d] < 3) ? int'(osz[d]) : 3));
        end
      end
      pick = $urandom_range(0, NFIELDS - 1);
      if (kind == 7) usz[pick] = '0;
      if (kind == 8) usz[pick] = osz[pick] + 16'd1;
      feed_idles = ($urandom_range(0, 3) != 0);
      sink_idles = ($urandom_range(0, 3) != 0);
      configure(osz, usz);

      blocks = $urandom_range(2, 5);
      repeat (blocks) begin
        // Now and then the sender waits for every write before going on.
        if ($urandom_range(0, 5) == 0) drain();
        push_request(make_start(pick_index(osz[0]), pick_index(osz[1]),
                                pick_index(osz[2]), pick_index(osz[3])));
        items_sent++;
        count = 1;
        for (d = 0; d < NFIELDS; d++) count = count * int'(usz[d]);
        roll = $urandom_range(0, 9);
        if (roll == 0 && count > 1) count = $urandom_range(1, count - 1);
        push_elements(count);
        items_sent += count;
        if (roll == 1) push_elements($urandom_range(1, 3));
      end
    end

    drain();
    repeat (START_SETTLE) @(posedge clk);
    if (mismatches == 0)
      $display("slice_update_address_generator_unit_tb passed");
    else
      $display("slice_update_address_generator_unit_tb failed");
    $finish;
  end

endmodule
